[rtl/core/argb32_source_over_blend_unit_assert.svh]
// Assertion macros for the source-over blend unit.
// Depends on nothing; bodies are empty when SYNTH is defined.
`ifndef ARGB32_SOURCE_OVER_BLEND_UNIT_ASSERT_SVH
`define ARGB32_SOURCE_OVER_BLEND_UNIT_ASSERT_SVH
`ifndef SYNTH
`define ASOB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("blend unit check failed");
`define ASOB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("blend unit check failed");
`else
`define ASOB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASOB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/asob_pkg.sv]
// Types and constants shared by the source-over blend unit.
// Depends on nothing.
`timescale 1ns / 1ps
package asob_pkg;
	localparam int unsigned LANES = 4;
	localparam int unsigned GA_W = 9;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [15:0] ROUND_BIAS = 16'h0080;
	localparam logic [GA_W-1:0] GA_RESET = 9'd256;

	typedef logic [LANES-1:0][15:0] prod4_t;

	typedef struct packed {
		logic pass_dst;
		logic pass_src;
		logic full;
		logic last;
	} ctl_t;
endpackage

[rtl/core/asob_if.sv]
// Channel interfaces: pixel request, blended result and configuration write.
// Depends on nothing.
`timescale 1ns / 1ps
interface asob_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_pixel;
	logic [31:0] dst_pixel;
	logic        last_pixel;
	modport source (output valid, src_pixel, dst_pixel, last_pixel, input ready);
	modport sink (input valid, src_pixel, dst_pixel, last_pixel, output ready);
endinterface

interface asob_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_pixel;
	logic        changed;
	logic        last_out;
	modport source (output valid, out_pixel, changed, last_out, input ready);
	modport sink (input valid, out_pixel, changed, last_out, output ready);
endinterface

interface asob_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] global_alpha;
	modport source (output valid, global_alpha, input ready);
	modport sink (input valid, global_alpha, output ready);
endinterface

[rtl/core/asob_prod.sv]
// Four byte lanes of x*a plus rounding bias.
// Depends on asob_pkg.
`timescale 1ns / 1ps
module asob_prod (
	input  logic [31:0]     pixel,
	input  logic [7:0]      alpha,
	output asob_pkg::prod4_t prod
);
	import asob_pkg::*;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		assign prod[k] = {8'd0, pixel[8*k +: 8]} * {8'd0, alpha} + ROUND_BIAS;
	end
endmodule

[rtl/core/asob_round.sv]
// Folds biased lane products into bytes: (t + (t >> 8)) >> 8.
// Depends on asob_pkg.
`timescale 1ns / 1ps
module asob_round (
	input  asob_pkg::prod4_t prod,
	output logic [31:0]      pixel
);
	import asob_pkg::*;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic [16:0] sum;
		assign sum = {1'b0, prod[k]} + {9'd0, prod[k][15:8]};
		assign pixel[8*k +: 8] = sum[15:8];
	end
endmodule

[rtl/core/argb32_source_over_blend_unit.sv]
// Top level of the premultiplied ARGB32 source-over blend unit.
// Depends on asob_pkg, asob_if, asob_prod, asob_round and the assertion header.
//
// Channel   Role   Payload
// cfg       sink   global_alpha (9 bits)
// pix       sink   src_pixel, dst_pixel, last_pixel
// blend     source out_pixel, changed, last_out
//
// Four register stages: scale products, scaled source, destination products,
// result register. One pixel per clock while blend.ready does not stall the output.
// Each stage loads when empty or when the stage after it moves, so bubbles
// close up under a stall and nothing is dropped or repeated.
// arst_n clears the valid bits and sets global_alpha to 256.
`timescale 1ns / 1ps
`include "argb32_source_over_blend_unit_assert.svh"
module argb32_source_over_blend_unit (
	input logic     clk,
	input logic     arst_n,
	asob_cfg_if.sink cfg,
	asob_pix_if.sink pix,
	asob_res_if.source blend
);
	import asob_pkg::*;

	logic [GA_W-1:0] global_alpha_q;
	logic            ga_full;
	logic            ga_zero;
	logic [7:0]      ca;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	prod4_t      prod_in;
	prod4_t      prod_s1;
	logic [31:0] src_s1, dst_s1;
	ctl_t        ctl_in, ctl_s1;

	logic [31:0] scaled;
	logic [31:0] sc_s2, dst_s2;
	ctl_t        ctl_s2;

	prod4_t      prod_d;
	prod4_t      prod_s3;
	logic [31:0] sc_s3, dst_s3;
	ctl_t        ctl_s3;

	logic [31:0] dmul;
	logic [31:0] blended;
	logic [31:0] result;
	logic [31:0] out_s4, dst_s4;
	ctl_t        ctl_s4;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_alpha_q <= GA_RESET;
		end else if (cfg.valid) begin
			global_alpha_q <= cfg.global_alpha;
		end
	end

	// values 256..511 are full opacity; for 1..255 ca = (ga*255)>>8 = ga-1
	assign ga_full = global_alpha_q[GA_W-1];
	assign ga_zero = (global_alpha_q == '0);
	assign ca      = global_alpha_q[7:0] - 8'd1;

	// stage handshake
	assign adv_s4    = !vld_s4 || blend.ready;
	assign adv_s3    = !vld_s3 || adv_s4;
	assign adv_s2    = !vld_s2 || adv_s3;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign pix.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= pix.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
		end
	end

	// stage 1: classify and scale source by ca
	assign ctl_in.full     = ga_full;
	assign ctl_in.pass_dst = ga_zero || (pix.src_pixel == '0);
	assign ctl_in.pass_src = ga_full && (pix.src_pixel[31:24] == ALPHA_OPAQUE);
	assign ctl_in.last     = pix.last_pixel;

	asob_prod u_prod_src (
		.pixel (pix.src_pixel),
		.alpha (ca),
		.prod  (prod_in)
	);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			prod_s1 <= prod_in;
			src_s1  <= pix.src_pixel;
			dst_s1  <= pix.dst_pixel;
			ctl_s1  <= ctl_in;
		end
	end

	// stage 2: fold scaled source
	asob_round u_round_src (
		.prod  (prod_s1),
		.pixel (scaled)
	);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			sc_s2  <= ctl_s1.full ? src_s1 : scaled;
			dst_s2 <= dst_s1;
			ctl_s2 <= ctl_s1;
		end
	end

	// stage 3: scale destination by inverse source alpha
	asob_prod u_prod_dst (
		.pixel (dst_s2),
		.alpha (ALPHA_OPAQUE - sc_s2[31:24]),
		.prod  (prod_d)
	);

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			prod_s3 <= prod_d;
			sc_s3   <= sc_s2;
			dst_s3  <= dst_s2;
			ctl_s3  <= ctl_s2;
		end
	end

	// stage 4: fold, add lanes, select
	asob_round u_round_dst (
		.prod  (prod_s3),
		.pixel (dmul)
	);

	for (genvar k = 0; k < LANES; k++) begin : g_add
		assign blended[8*k +: 8] = sc_s3[8*k +: 8] + dmul[8*k +: 8];
	end

	always_comb begin
		if (ctl_s3.pass_dst) begin
			result = dst_s3;
		end else if (ctl_s3.pass_src) begin
			result = sc_s3;
		end else begin
			result = blended;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			out_s4 <= result;
			dst_s4 <= dst_s3;
			ctl_s4 <= ctl_s3;
		end
	end

	assign blend.valid     = vld_s4;
	assign blend.out_pixel = out_s4;
	assign blend.changed   = !ctl_s4.pass_dst;
	assign blend.last_out  = ctl_s4.last;

	`ASOB_ASSERT_NEXT(a_take_request, clk, arst_n, pix.valid && pix.ready, vld_s1)
	`ASOB_ASSERT_NEXT(a_hold_s2, clk, arst_n, vld_s2 && !adv_s2, vld_s2 && $stable(sc_s2))
	`ASOB_ASSERT_SAME(a_skip_keeps_dst, clk, arst_n, vld_s4 && ctl_s4.pass_dst, out_s4 == dst_s4)
	`ASOB_ASSERT_SAME(a_opaque_full, clk, arst_n, vld_s1 && ctl_s1.pass_src, ctl_s1.full)
endmodule

[tb/tb_top.sv]
// Self-checking bench for argb32_source_over_blend_unit: directed and random pixel requests,
// with every result checked against an in-bench source-over predictor.
// Depends on asob_pkg, asob_if and the blend unit RTL.
`timescale 1ns / 1ps
module tb_top;
	import asob_pkg::*;

	localparam logic [GA_W-1:0] FULL_OPACITY = 9'd256;
	localparam int unsigned PHASE_PIXELS = 200;
	localparam int unsigned HOLD_CYCLES = 120;
	localparam int unsigned MAX_PRINTED = 100;

	typedef struct packed {
		logic [31:0] out_pixel;
		logic        changed;
		logic        last_out;
	} blend_result_t;

	class blend_scoreboard;
		blend_result_t   expected_blends[$];
		logic [GA_W-1:0] alpha;
		int unsigned     mismatches;

		function new();
			alpha = GA_RESET;
			mismatches = 0;
		endfunction

		function logic [7:0] scale_byte(logic [7:0] x, logic [7:0] a);
			logic [16:0] t;
			t = 17'(x) * 17'(a) + 17'h80;
			return 8'((t + (t >> 8)) >> 8);
		endfunction

		function logic [31:0] scale_pixel(logic [31:0] p, logic [7:0] a);
			logic [31:0] r;
			for (int k = 0; k < 4; k++)
				r[8*k +: 8] = scale_byte(p[8*k +: 8], a);
			return r;
		endfunction

		function logic [31:0] source_over(logic [31:0] s, logic [31:0] d);
			logic [31:0] m;
			logic [31:0] r;
			m = scale_pixel(d, 8'hff - s[31:24]);
			for (int k = 0; k < 4; k++)
				r[8*k +: 8] = s[8*k +: 8] + m[8*k +: 8];
			return r;
		endfunction

		function blend_result_t predict_result(logic [31:0] src, logic [31:0] dst, logic last);
			logic [GA_W-1:0] ga;
			logic [7:0]      ca;
			blend_result_t   r;
			ga = (alpha > FULL_OPACITY) ? FULL_OPACITY : alpha;
			r.out_pixel = dst;
			r.changed = 1'b0;
			r.last_out = last;
			if (ga == FULL_OPACITY) begin
				if (src[31:24] == ALPHA_OPAQUE) begin
					r.out_pixel = src;
					r.changed = 1'b1;
				end else if (src != 32'h0) begin
					r.out_pixel = source_over(src, dst);
					r.changed = 1'b1;
				end
			end else if (ga != '0 && src != 32'h0) begin
				ca = 8'((17'(ga) * 17'd255) >> 8);
				r.out_pixel = source_over(scale_pixel(src, ca), dst);
				r.changed = 1'b1;
			end
			return r;
		endfunction

		function int unsigned pending();
			return expected_blends.size();
		endfunction

		task report(string msg);
			if (mismatches < MAX_PRINTED)
				$display("%0t mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		function void note_request(logic [31:0] src, logic [31:0] dst, logic last);
			expected_blends.push_back(predict_result(src, dst, last));
		endfunction

		task check_result(logic [31:0] out_pixel, logic changed, logic last_out);
			blend_result_t e;
			if (expected_blends.size() == 0) begin
				report($sformatf("unexpected result out_pixel=%h", out_pixel));
				return;
			end
			e = expected_blends.pop_front();
			if (out_pixel !== e.out_pixel)
				report($sformatf("out_pixel %h, want %h", out_pixel, e.out_pixel));
			if (changed !== e.changed)
				report($sformatf("changed %b, want %b", changed, e.changed));
			if (last_out !== e.last_out)
				report($sformatf("last_out %b, want %b", last_out, e.last_out));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   tx_idle;
	bit   rx_idle;
	bit   hold_req;

	blend_scoreboard board = new();

	asob_cfg_if cfg();
	asob_pix_if pix();
	asob_res_if blend();

	argb32_source_over_blend_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pix    (pix),
		.blend  (blend)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("** argb32_source_over_blend_unit: FAILED **");
		$finish;
	end

	task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst, input logic last);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.src_pixel <= src;
		pix.dst_pixel <= dst;
		pix.last_pixel <= last;
		do @(posedge clk); while (!pix.ready);
		board.note_request(src, dst, last);
	endtask

	task automatic wait_drained();
		pix.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_alpha(input logic [GA_W-1:0] value);
		wait_drained();
		repeat (6) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.global_alpha <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		board.alpha = value;
	endtask

	function automatic logic [31:0] random_pixel();
		int unsigned roll;
		logic [7:0]  a;
		roll = $urandom_range(0, 9);
		a = 8'($urandom_range(0, 255));
		if (roll == 0)
			return 32'h0;
		if (roll == 1)
			return {ALPHA_OPAQUE, 24'($urandom)};
		if (roll == 2)
			return {8'h00, 24'($urandom)};
		if (roll <= 4)
			return $urandom;
		return {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
			8'($urandom_range(0, a))};
	endfunction

	// result sink: random back-pressure, one long hold-off on request
	initial begin : result_sink
		int unsigned stall;
		blend.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = rx_idle ? $urandom_range(0, 15) : 0;
			end
			if (stall != 0) begin
				blend.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			blend.ready <= 1'b1;
			do @(posedge clk); while (!blend.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && blend.valid && blend.ready)
			board.check_result(blend.out_pixel, blend.changed, blend.last_out);
	end

	initial begin : stimulus
		logic [GA_W-1:0] phase_alpha [8];
		phase_alpha = '{9'd256, 9'd0, 9'd128, 9'd511, 9'd1, 9'd255, 9'd257, 9'd256};
		phase_alpha[7] = GA_W'($urandom_range(0, 511));
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		pix.valid <= 1'b0;
		pix.src_pixel <= '0;
		pix.dst_pixel <= '0;
		pix.last_pixel <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.global_alpha <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// full opacity after reset
		send_pixel(32'hff000000, 32'h12345678, 1'b0);
		send_pixel(32'hffffffff, 32'h00000000, 1'b0);
		send_pixel(32'h00000000, 32'hffffffff, 1'b0);
		send_pixel(32'h80402010, 32'hffffffff, 1'b1);
		send_pixel(32'h01000000, 32'h80808080, 1'b0);
		send_pixel(32'h00000001, 32'hffffffff, 1'b0);
		send_pixel(32'h10ffffff, 32'hffffffff, 1'b0);
		send_pixel(32'hfe010203, 32'h00ff00ff, 1'b1);
		write_alpha(9'd0);
		send_pixel(32'hffffffff, 32'h0a0b0c0d, 1'b0);
		send_pixel(32'h00000000, 32'hffffffff, 1'b1);
		write_alpha(9'd511);
		send_pixel(32'hff804020, 32'h11223344, 1'b0);
		send_pixel(32'h00000000, 32'h55667788, 1'b0);
		send_pixel(32'h7f7f7f7f, 32'hffffffff, 1'b1);
		write_alpha(9'd1);
		send_pixel(32'hffffffff, 32'h00000000, 1'b0);
		send_pixel(32'h00000000, 32'h80808080, 1'b0);
		send_pixel(32'hff000000, 32'hffffffff, 1'b1);
		write_alpha(9'd255);
		send_pixel(32'hffffffff, 32'hffffffff, 1'b0);
		send_pixel(32'h80ffffff, 32'h00000000, 1'b1);
		write_alpha(9'd257);
		send_pixel(32'hff000001, 32'h00000000, 1'b0);

		for (int p = 0; p < 8; p++) begin
			write_alpha(phase_alpha[p]);
			tx_idle = (p % 3 != 1);
			rx_idle = (p % 4 != 1);
			if (p == 1)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				// drain fully midway through one phase
				if (p == 3 && i == PHASE_PIXELS / 2)
					wait_drained();
				send_pixel(random_pixel(), random_pixel(),
					(i == PHASE_PIXELS - 1) || ($urandom_range(0, 31) == 0));
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("** argb32_source_over_blend_unit: PASSED **");
		else
			$display("** argb32_source_over_blend_unit: FAILED **");
		$finish;
	end
endmodule
